[rtl/core/ilw_pkg.sv]
// shared constants, register codes and a byte helper for the ilike matcher
`timescale 1ns / 1ps

package ilw_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int BYTE_W          = 8;
    localparam int PAT_REGS        = 4;
    localparam int PAT_REG_W       = 64;
    localparam int REG_BYTES       = PAT_REG_W / BYTE_W;
    localparam int STORED_BYTES    = PAT_REGS * REG_BYTES;
    localparam int CFG_LEN_W       = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
    localparam logic [BYTE_W-1:0] UND_CHAR = 8'h5F;
    localparam logic [BYTE_W-1:0] UPPER_LO = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_HI = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_A      = 3'd1,
        REG_PATTERN_B      = 3'd2,
        REG_PATTERN_C      = 3'd3,
        REG_PATTERN_D      = 3'd4
    } cfg_reg_t;

    // ascii lower-casing, high bytes untouched
    function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] c);
        lower_byte = (c >= UPPER_LO && c <= UPPER_HI) ? c + CASE_OFS : c;
    endfunction

endpackage

[rtl/core/ilike_wildcard_matcher.sv]
// top level of the case-insensitive sql ilike matcher
`timescale 1ns / 1ps

// Streams text one byte per word and matches it against a pattern of up to
// MAX_PATTERN bytes ('%' any run, '_' one byte, other bytes compared after ascii
// lower-casing). A new word is taken every cycle unless an end-of-text word is
// held behind a match bit that has not been read; a word passes an input
// register, the row update, and for end-of-text words the result register, so
// a match bit is offered after both of those registers. The cycle time is
// set by the row update: the choice of the initial row (itself a prefix scan over
// the pattern registers), one byte compare per pattern position, then a
// log2(MAX_PATTERN)-level prefix scan over the wildcard runs. Write the
// configuration registers only while no word is in flight.
module ilike_wildcard_matcher
    import ilw_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  end_of_text,
    input  logic                  no_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  matched
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]                   len_eff;
    logic [MAX_PATTERN-1:0]             pct_mask;
    logic [MAX_PATTERN-1:0]             und_mask;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_low;
    logic [MAX_PATTERN:0]               en_mask;
    logic [MAX_PATTERN:0]               init_row;

    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     text_reg;
    logic                  eot_reg;
    logic                  nob_reg;
    logic [MAX_PATTERN:0]  row_reg;
    logic                  start_reg;
    logic                  out_valid_reg;
    logic                  matched_reg;

    logic [MAX_PATTERN:0]  row_next;
    logic                  match_next;
    logic                  advance;

    ilw_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .len_eff   (len_eff),
        .pct_mask  (pct_mask),
        .und_mask  (und_mask),
        .pat_low   (pat_low),
        .en_mask   (en_mask),
        .init_row  (init_row)
    );

    ilw_step #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_step (
        .row       (row_reg),
        .at_start  (start_reg),
        .text_byte (text_reg),
        .no_byte   (nob_reg),
        .len_eff   (len_eff),
        .pct_mask  (pct_mask),
        .und_mask  (und_mask),
        .pat_low   (pat_low),
        .en_mask   (en_mask),
        .init_row  (init_row),
        .row_next  (row_next),
        .match_bit (match_next)
    );

    // an end-of-text word moves on only when the result register is free or its match bit is being read
    assign advance  = in_valid_reg && (!eot_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            text_reg <= text_byte;
            eot_reg  <= end_of_text;
            nob_reg  <= no_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= {{MAX_PATTERN{1'b0}}, 1'b1};
            start_reg <= 1'b1;
        end
        else if (advance)
        begin
            if (eot_reg)
            begin
                start_reg <= 1'b1;
            end
            else if (!nob_reg)
            begin
                row_reg   <= row_next;
                start_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && eot_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && eot_reg)
        begin
            matched_reg <= match_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    a_result_from_eot: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg ##1 out_valid_reg |-> $past(advance && eot_reg))
        else $error("result word appeared without an end-of-text word");

    a_rearm_after_eot: assert property (@(posedge clk) disable iff (!rst_n)
        advance && eot_reg |=> start_reg)
        else $error("row not re-armed after end of text");

    a_eot_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && eot_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while a finished match could not be stored");

    a_empty_prefix_dies: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !eot_reg && !nob_reg |=> !row_reg[0] && !start_reg)
        else $error("empty prefix still matching after a byte");

endmodule

[rtl/core/ilw_scan.sv]
// segmented prefix or-scan (kogge-stone), used for runs of wildcard positions
`timescale 1ns / 1ps

module ilw_scan
    import ilw_pkg::*;
#(
    parameter int W = MAX_PATTERN_DEF
) (
    input  logic [W-1:0] gen,
    input  logic [W-1:0] prop,
    input  logic         carry_in,
    output logic [W-1:0] result
);

    localparam int LVL = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0] g_lvl [0:LVL];
    logic [W-1:0] p_lvl [0:LVL];

    // result[j] = gen[j] | prop[j] & result[j-1], result[-1] = carry_in
    always_comb
    begin
        g_lvl[0] = gen;
        p_lvl[0] = prop;
        for (int l = 0; l < LVL; l++)
        begin
            for (int j = 0; j < W; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
                    p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
                end
                else
                begin
                    g_lvl[l+1][j] = g_lvl[l][j];
                    p_lvl[l+1][j] = p_lvl[l][j];
                end
            end
        end
    end

    assign result = g_lvl[LVL] | (p_lvl[LVL] & {W{carry_in}});

endmodule

[rtl/core/ilw_cfg.sv]
// pattern registers, per-position decode and the initial match row
`timescale 1ns / 1ps

module ilw_cfg
    import ilw_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic [LEN_W-1:0]              len_eff,
    output logic [MAX_PATTERN-1:0]        pct_mask,
    output logic [MAX_PATTERN-1:0]        und_mask,
    output logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_low,
    output logic [MAX_PATTERN:0]          en_mask,
    output logic [MAX_PATTERN:0]          init_row
);

    logic [CFG_LEN_W-1:0]                     pattern_length_reg;
    logic [PAT_REGS-1:0][PAT_REG_W-1:0]       pattern_reg;
    logic [PAT_REGS*PAT_REG_W-1:0]            pat_flat;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]       pat_raw;
    logic [MAX_PATTERN-1:0]                   init_scan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[CFG_LEN_W-1:0];
                REG_PATTERN_A:      pattern_reg[0]     <= cfg_data;
                REG_PATTERN_B:      pattern_reg[1]     <= cfg_data;
                REG_PATTERN_C:      pattern_reg[2]     <= cfg_data;
                REG_PATTERN_D:      pattern_reg[3]     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // lengths above the row size saturate
    assign len_eff = (32'(pattern_length_reg) > 32'(MAX_PATTERN))
                   ? LEN_W'(MAX_PATTERN) : LEN_W'(pattern_length_reg);

    assign pat_flat = pattern_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_pos
            if (k < STORED_BYTES)
            begin : g_stored
                assign pat_raw[k] = pat_flat[k*BYTE_W +: BYTE_W];
            end
            else
            begin : g_blank
                assign pat_raw[k] = '0;
            end
            assign pat_low[k]  = lower_byte(pat_raw[k]);
            assign pct_mask[k] = (pat_raw[k] == PCT_CHAR);
            assign und_mask[k] = (pat_raw[k] == UND_CHAR);
        end
        for (k = 0; k <= MAX_PATTERN; k++)
        begin : g_en
            assign en_mask[k] = (32'(k) <= 32'(len_eff));
        end
    endgenerate

    // prefix j matches the empty text only if bytes 0..j-1 are all '%'
    ilw_scan #(
        .W (MAX_PATTERN)
    ) u_init_scan (
        .gen      ('0),
        .prop     (pct_mask),
        .carry_in (1'b1),
        .result   (init_scan)
    );

    assign init_row = {init_scan, 1'b1} & en_mask;

endmodule

[rtl/core/ilw_step.sv]
// one text byte applied to the match row, plus the match bit at that point
`timescale 1ns / 1ps

module ilw_step
    import ilw_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN:0]               row,
    input  logic                               at_start,
    input  logic [BYTE_W-1:0]                  text_byte,
    input  logic                               no_byte,
    input  logic [LEN_W-1:0]                   len_eff,
    input  logic [MAX_PATTERN-1:0]             pct_mask,
    input  logic [MAX_PATTERN-1:0]             und_mask,
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_low,
    input  logic [MAX_PATTERN:0]               en_mask,
    input  logic [MAX_PATTERN:0]               init_row,
    output logic [MAX_PATTERN:0]               row_next,
    output logic                               match_bit
);

    logic [MAX_PATTERN:0]   base_row;
    logic [BYTE_W-1:0]      text_fold;
    logic [MAX_PATTERN-1:0] gen;
    logic [MAX_PATTERN-1:0] scan_out;
    logic [MAX_PATTERN:0]   applied;

    // a fresh string starts from the row of the current pattern
    assign base_row  = at_start ? init_row : row;
    assign text_fold = lower_byte(text_byte);

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (pct_mask[i])
                gen[i] = base_row[i+1];
            else
                gen[i] = base_row[i] & (und_mask[i] | (text_fold == pat_low[i]));
        end
    end

    // runs of '%' carry the new bit of the position before them upward
    ilw_scan #(
        .W (MAX_PATTERN)
    ) u_step_scan (
        .gen      (gen),
        .prop     (pct_mask),
        .carry_in (1'b0),
        .result   (scan_out)
    );

    assign applied   = {scan_out, 1'b0} & en_mask;
    assign row_next  = no_byte ? base_row : applied;
    assign match_bit = row_next[len_eff];

endmodule
